[rtl/core/grb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette breeder package
// Shared field widths, codes and constants of the breeding engine.
// ----------------------------------------------------------------------------
package grb_pkg;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int WORD_W   = 64;
    localparam int FIT_W    = 32;
    localparam int PAR_W    = 6;
    localparam int CUT_W    = 7;
    localparam int STAT_W   = 2;
    localparam int THR_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int LFSR_W   = 32;

    localparam int GENE_BITS_DEF = 64;
    localparam int COLONY_DEF    = 64;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BREED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SLOT = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CROSSOVER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTATION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd2;

    localparam logic [THR_W-1:0]  CROSSOVER_RESET = 10'd900;
    localparam logic [THR_W-1:0]  MUTATION_RESET  = 10'd900;
    localparam logic [LFSR_W-1:0] SEED_RESET      = 32'd1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS       = 32'h8020_0003;

    // x mod 1000 for 32-bit x: q = (x * RECIP) >> RECIP_SHIFT is exact.
    localparam logic [31:0] DRAW_MOD    = 32'd1000;
    localparam logic [31:0] RECIP       = 32'd2199023256;
    localparam int          RECIP_SHIFT = 41;

endpackage

[rtl/core/grb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette breeder channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface grb_req_if;
    logic                          valid;
    logic                          ready;
    logic [grb_pkg::MODE_W-1:0]    mode;
    logic [grb_pkg::SLOT_W-1:0]    slot;
    logic [grb_pkg::WORD_W-1:0]    gene_word;
    logic [grb_pkg::FIT_W-1:0]     fitness_value;

    modport source (output valid, mode, slot, gene_word, fitness_value, input ready);
    modport sink   (input valid, mode, slot, gene_word, fitness_value, output ready);
endinterface

interface grb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [grb_pkg::WORD_W-1:0]    chromosome_out;
    logic [grb_pkg::PAR_W-1:0]     parent_first;
    logic [grb_pkg::PAR_W-1:0]     parent_second;
    logic [grb_pkg::CUT_W-1:0]     cut_point;
    logic [grb_pkg::STAT_W-1:0]    status;

    modport source (output valid, chromosome_out, parent_first, parent_second,
                    cut_point, status, input ready);
    modport sink   (input valid, chromosome_out, parent_first, parent_second,
                    cut_point, status, output ready);
endinterface

[rtl/core/grb_mod_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette breeder remainder unit
// Restoring radix-2 remainder of two 32-bit words, one bit per cycle.
// ----------------------------------------------------------------------------
module grb_mod_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [grb_pkg::FIT_W-1:0]    dividend,
    input  logic [grb_pkg::FIT_W-1:0]    divisor,
    output logic                         done,
    output logic [grb_pkg::FIT_W-1:0]    remainder
);

    logic [grb_pkg::FIT_W-1:0] rem_reg;
    logic [grb_pkg::FIT_W-1:0] dvd_reg;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [grb_pkg::FIT_W:0]   rem_shift;
    logic [grb_pkg::FIT_W:0]   rem_diff;
    logic [grb_pkg::FIT_W-1:0] rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[grb_pkg::FIT_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        if (rem_shift >= {1'b0, divisor})
        begin
            rem_next = rem_diff[grb_pkg::FIT_W-1:0];
        end
        else
        begin
            rem_next = rem_shift[grb_pkg::FIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[grb_pkg::FIT_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/genetic_roulette_breeder_unit.sv]
`timescale 1ns / 1ps
// Load, read and commit each end in S_FINISH, which loads the response register.
// Breed time grows with k, the index each roulette scan stops at, and with c, the crossover
// point: the scans read the fitness memory in S_SCAN_ISSUE and S_SCAN_CMP for each entry,
// each crossover or mutation draw goes through the draw_reg and prod_reg modulo path, and
// each parent draw through grb_mod_div. One transaction is in work at a time. After reset
// the block sweeps the fitness memory, holding req.ready low, before taking its first transaction.
// ----------------------------------------------------------------------------
// Genetic roulette breeder unit
// Colony store with roulette parent selection, single-point crossover and
// bitwise mutation, built around single-port-read synchronous memories.
// ----------------------------------------------------------------------------
module genetic_roulette_breeder_unit
#(
    parameter int GENE_BITS = grb_pkg::GENE_BITS_DEF,
    parameter int COLONY    = grb_pkg::COLONY_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    grb_req_if.sink                           req,
    grb_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [grb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [grb_pkg::CFG_DAT_W-1:0]     cfg_data
);

    localparam int CIDX = $clog2(COLONY);
    localparam int CUTW = $clog2(GENE_BITS + 1);
    localparam int BITW = $clog2(GENE_BITS);
    localparam logic [CIDX-1:0] LAST_IDX = CIDX'(COLONY - 1);
    localparam logic [CUTW-1:0] CUT_MAX  = CUTW'(GENE_BITS);
    localparam logic [BITW-1:0] BIT_LAST = BITW'(GENE_BITS - 1);

    // Sequencer state codes.
    localparam logic [4:0] S_SWEEP      = 5'd0;
    localparam logic [4:0] S_SWEEP_END  = 5'd1;
    localparam logic [4:0] S_IDLE       = 5'd2;
    localparam logic [4:0] S_LOAD_WAIT  = 5'd3;
    localparam logic [4:0] S_LOAD_WR    = 5'd4;
    localparam logic [4:0] S_READ_WAIT  = 5'd5;
    localparam logic [4:0] S_READ_DONE  = 5'd6;
    localparam logic [4:0] S_TOT_WAIT   = 5'd7;
    localparam logic [4:0] S_TOT_CHK    = 5'd8;
    localparam logic [4:0] S_DRAW_P     = 5'd9;
    localparam logic [4:0] S_DIV_WAIT   = 5'd10;
    localparam logic [4:0] S_SCAN_ISSUE = 5'd11;
    localparam logic [4:0] S_SCAN_CMP   = 5'd12;
    localparam logic [4:0] S_GENE_A     = 5'd13;
    localparam logic [4:0] S_GENE_B     = 5'd14;
    localparam logic [4:0] S_GENE_C     = 5'd15;
    localparam logic [4:0] S_DRAW       = 5'd16;
    localparam logic [4:0] S_MUL        = 5'd17;
    localparam logic [4:0] S_CMP        = 5'd18;
    localparam logic [4:0] S_CHILD      = 5'd19;
    localparam logic [4:0] S_WRITE      = 5'd20;
    localparam logic [4:0] S_FINISH     = 5'd21;

    // Colony storage. Gene memories have no reset; the fitness memory is
    // cleared by the sweep that follows reset and every commit.
    logic [GENE_BITS-1:0]          cur_mem  [COLONY];
    logic [GENE_BITS-1:0]          next_mem [COLONY];
    logic [grb_pkg::FIT_W-1:0]     fit_mem  [COLONY];

    logic [GENE_BITS-1:0]          cur_rdata_reg;
    logic [GENE_BITS-1:0]          next_rdata_reg;
    logic [grb_pkg::FIT_W-1:0]     fit_rdata_reg;

    logic [CIDX-1:0]               cur_raddr;
    logic                          cur_we;
    logic [CIDX-1:0]               cur_waddr;
    logic [GENE_BITS-1:0]          cur_wdata;
    logic [CIDX-1:0]               fit_raddr;
    logic                          fit_we;
    logic [CIDX-1:0]               fit_waddr;
    logic [grb_pkg::FIT_W-1:0]     fit_wdata;

    logic [4:0]                    state_reg;
    logic [4:0]                    state_next;

    // Latched request fields.
    logic [grb_pkg::SLOT_W-1:0]    slot_reg;
    logic [GENE_BITS-1:0]          gene_reg;
    logic [grb_pkg::FIT_W-1:0]     fit_in_reg;
    logic [CIDX+grb_pkg::SLOT_W-1:0] slot_ext;
    logic [CIDX-1:0]               slot_addr;
    logic                          req_slot_ok;

    // Configuration and random source.
    logic [grb_pkg::THR_W-1:0]     xo_thr_reg;
    logic [grb_pkg::THR_W-1:0]     mu_thr_reg;
    logic [grb_pkg::LFSR_W-1:0]    lfsr_reg;
    logic [grb_pkg::LFSR_W-1:0]    lfsr_next;
    logic                          draw_step;

    // Breeding datapath.
    logic [CIDX-1:0]               sweep_idx_reg;
    logic                          copy_vld_reg;
    logic [CIDX-1:0]               copy_addr_reg;
    logic                          emit_reg;
    logic [grb_pkg::FIT_W-1:0]     total_reg;
    logic                          second_reg;
    logic [grb_pkg::FIT_W-1:0]     pick_reg;
    logic [CIDX-1:0]               scan_idx_reg;
    logic [CIDX-1:0]               pa_reg;
    logic [CIDX-1:0]               pb_reg;
    logic [GENE_BITS-1:0]          gene_a_reg;
    logic [GENE_BITS-1:0]          gene_b_reg;
    logic [CUTW-1:0]               cut_reg;
    logic [BITW-1:0]               bit_reg;
    logic                          mut_phase_reg;
    logic [GENE_BITS-1:0]          child_reg;
    logic [GENE_BITS-1:0]          low_mask;
    logic [grb_pkg::LFSR_W-1:0]    draw_reg;
    logic [63:0]                   prod_reg;
    logic [31:0]                   quot_scaled;
    logic [31:0]                   draw_rem;
    logic [grb_pkg::THR_W-1:0]     draw_mod;
    logic [grb_pkg::FIT_W:0]       load_sum;
    logic [grb_pkg::FIT_W-1:0]     load_prev;
    logic [grb_pkg::FIT_W-1:0]     load_total;
    logic                          div_start;
    logic                          div_done;
    logic [grb_pkg::FIT_W-1:0]     div_rem;
    logic [CIDX+grb_pkg::PAR_W-1:0] pa_ext;
    logic [CIDX+grb_pkg::PAR_W-1:0] pb_ext;

    // Pending response fields and the output register.
    logic [GENE_BITS-1:0]          res_chrom_reg;
    logic [grb_pkg::PAR_W-1:0]     res_pa_reg;
    logic [grb_pkg::PAR_W-1:0]     res_pb_reg;
    logic [CUTW-1:0]               res_cut_reg;
    logic [grb_pkg::STAT_W-1:0]    res_status_reg;
    logic                          out_vld_reg;
    logic [grb_pkg::WORD_W-1:0]    out_chrom_reg;
    logic [grb_pkg::PAR_W-1:0]     out_pa_reg;
    logic [grb_pkg::PAR_W-1:0]     out_pb_reg;
    logic [grb_pkg::CUT_W-1:0]     out_cut_reg;
    logic [grb_pkg::STAT_W-1:0]    out_status_reg;
    logic                          out_load;

    assign req.ready   = (state_reg == S_IDLE);
    assign req_slot_ok = (32'(req.slot) < COLONY);
    assign slot_ext    = {{CIDX{1'b0}}, slot_reg};
    assign slot_addr   = slot_ext[CIDX-1:0];
    assign pa_ext      = {{grb_pkg::PAR_W{1'b0}}, pa_reg};
    assign pb_ext      = {{grb_pkg::PAR_W{1'b0}}, pb_reg};

    // Galois LFSR, one step per draw.
    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? grb_pkg::LFSR_TAPS : '0);
    assign draw_step = (state_reg == S_DRAW_P) ||
                       ((state_reg == S_DRAW) && (mut_phase_reg || (cut_reg != CUT_MAX)));
    assign div_start = (state_reg == S_DRAW_P);

    // Remainder modulo 1000 from the registered reciprocal product.
    assign quot_scaled = 32'(prod_reg[63:grb_pkg::RECIP_SHIFT]) * grb_pkg::DRAW_MOD;
    assign draw_rem    = draw_reg - quot_scaled;
    assign draw_mod    = draw_rem[grb_pkg::THR_W-1:0];

    // Saturating running total for a load.
    assign load_prev  = (slot_reg == '0) ? '0 : fit_rdata_reg;
    assign load_sum   = {1'b0, load_prev} + {1'b0, fit_in_reg};
    assign load_total = load_sum[grb_pkg::FIT_W] ? '1 : load_sum[grb_pkg::FIT_W-1:0];

    always_comb
    begin
        for (int i = 0; i < GENE_BITS; i++)
        begin
            low_mask[i] = (CUTW'(i) < cut_reg);
        end
    end

    grb_mod_div u_mod_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (lfsr_next),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Memory port selection.
    always_comb
    begin
        cur_raddr = slot_addr;
        if (state_reg == S_GENE_A)
        begin
            cur_raddr = pa_reg;
        end
        else if (state_reg == S_GENE_B)
        begin
            cur_raddr = pb_reg;
        end

        fit_raddr = scan_idx_reg;
        if (state_reg == S_LOAD_WAIT)
        begin
            fit_raddr = slot_addr - CIDX'(1);
        end
        else if (state_reg == S_TOT_WAIT)
        begin
            fit_raddr = LAST_IDX;
        end

        cur_we    = 1'b0;
        cur_waddr = copy_addr_reg;
        cur_wdata = next_rdata_reg;
        fit_we    = 1'b0;
        fit_waddr = sweep_idx_reg;
        fit_wdata = '0;
        if (copy_vld_reg)
        begin
            cur_we = 1'b1;
        end
        if (state_reg == S_SWEEP)
        begin
            fit_we = 1'b1;
        end
        if (state_reg == S_LOAD_WR)
        begin
            cur_we    = 1'b1;
            cur_waddr = slot_addr;
            cur_wdata = gene_reg;
            fit_we    = 1'b1;
            fit_waddr = slot_addr;
            fit_wdata = load_total;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        if (state_reg == S_WRITE)
        begin
            next_mem[slot_addr] <= child_reg;
        end
        if (fit_we)
        begin
            fit_mem[fit_waddr] <= fit_wdata;
        end
        cur_rdata_reg  <= cur_mem[cur_raddr];
        next_rdata_reg <= next_mem[sweep_idx_reg];
        fit_rdata_reg  <= fit_mem[fit_raddr];
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP:
            begin
                if (sweep_idx_reg == LAST_IDX)
                begin
                    state_next = S_SWEEP_END;
                end
            end
            S_SWEEP_END:  state_next = emit_reg ? S_FINISH : S_IDLE;
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.mode == grb_pkg::MODE_COMMIT)
                    begin
                        state_next = S_SWEEP;
                    end
                    else if (!req_slot_ok)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (req.mode == grb_pkg::MODE_LOAD)
                    begin
                        state_next = S_LOAD_WAIT;
                    end
                    else if (req.mode == grb_pkg::MODE_READ)
                    begin
                        state_next = S_READ_WAIT;
                    end
                    else
                    begin
                        state_next = S_TOT_WAIT;
                    end
                end
            end
            S_LOAD_WAIT:  state_next = S_LOAD_WR;
            S_LOAD_WR:    state_next = S_FINISH;
            S_READ_WAIT:  state_next = S_READ_DONE;
            S_READ_DONE:  state_next = S_FINISH;
            S_TOT_WAIT:   state_next = S_TOT_CHK;
            S_TOT_CHK:    state_next = (fit_rdata_reg == '0) ? S_FINISH : S_DRAW_P;
            S_DRAW_P:     state_next = S_DIV_WAIT;
            S_DIV_WAIT:   state_next = div_done ? S_SCAN_ISSUE : S_DIV_WAIT;
            S_SCAN_ISSUE: state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if ((pick_reg < fit_rdata_reg) || (scan_idx_reg == LAST_IDX))
                begin
                    state_next = second_reg ? S_GENE_A : S_DRAW_P;
                end
                else
                begin
                    state_next = S_SCAN_ISSUE;
                end
            end
            S_GENE_A:     state_next = S_GENE_B;
            S_GENE_B:     state_next = S_GENE_C;
            S_GENE_C:     state_next = S_DRAW;
            S_DRAW:
            begin
                if (!mut_phase_reg && (cut_reg == CUT_MAX))
                begin
                    state_next = S_CHILD;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:        state_next = S_CMP;
            S_CMP:
            begin
                if (!mut_phase_reg)
                begin
                    state_next = (draw_mod > xo_thr_reg) ? S_CHILD : S_DRAW;
                end
                else
                begin
                    state_next = (bit_reg == BIT_LAST) ? S_WRITE : S_DRAW;
                end
            end
            S_CHILD:      state_next = S_DRAW;
            S_WRITE:      state_next = S_FINISH;
            S_FINISH:     state_next = out_load ? S_IDLE : S_FINISH;
            default:      state_next = S_IDLE;
        endcase
    end

    assign out_load = (state_reg == S_FINISH) && (!out_vld_reg || rsp.ready);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_idx_reg <= '0;
            copy_vld_reg  <= 1'b0;
            emit_reg      <= 1'b0;
            out_vld_reg   <= 1'b0;
            xo_thr_reg    <= grb_pkg::CROSSOVER_RESET;
            mu_thr_reg    <= grb_pkg::MUTATION_RESET;
            lfsr_reg      <= grb_pkg::SEED_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_SWEEP)
            begin
                copy_vld_reg  <= 1'b1;
                sweep_idx_reg <= sweep_idx_reg + CIDX'(1);
            end
            else
            begin
                copy_vld_reg  <= 1'b0;
                sweep_idx_reg <= '0;
            end

            if (state_reg == S_IDLE)
            begin
                emit_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            // A seed write restarts the sequence; zero would lock it up.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    grb_pkg::CFG_CROSSOVER: xo_thr_reg <= cfg_data[grb_pkg::THR_W-1:0];
                    grb_pkg::CFG_MUTATION:  mu_thr_reg <= cfg_data[grb_pkg::THR_W-1:0];
                    grb_pkg::CFG_SEED:
                    begin
                        lfsr_reg <= (cfg_data == '0) ? grb_pkg::SEED_RESET : cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (draw_step)
            begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                slot_reg       <= req.slot;
                gene_reg       <= req.gene_word[GENE_BITS-1:0];
                fit_in_reg     <= req.fitness_value;
                res_chrom_reg  <= '0;
                res_pa_reg     <= '0;
                res_pb_reg     <= '0;
                res_cut_reg    <= '0;
                res_status_reg <= (req.mode != grb_pkg::MODE_COMMIT && !req_slot_ok) ?
                                  grb_pkg::ST_SLOT : grb_pkg::ST_OK;
            end
            S_SWEEP:
            begin
                copy_addr_reg <= sweep_idx_reg;
            end
            S_READ_DONE:
            begin
                res_chrom_reg <= cur_rdata_reg;
            end
            S_TOT_CHK:
            begin
                total_reg  <= fit_rdata_reg;
                second_reg <= 1'b0;
                if (fit_rdata_reg == '0)
                begin
                    res_status_reg <= grb_pkg::ST_ZERO;
                end
            end
            S_DIV_WAIT:
            begin
                pick_reg     <= div_rem;
                scan_idx_reg <= '0;
            end
            S_SCAN_CMP:
            begin
                if ((pick_reg < fit_rdata_reg) || (scan_idx_reg == LAST_IDX))
                begin
                    second_reg <= 1'b1;
                    if (second_reg)
                    begin
                        pb_reg <= scan_idx_reg;
                    end
                    else
                    begin
                        pa_reg <= scan_idx_reg;
                    end
                end
                else
                begin
                    scan_idx_reg <= scan_idx_reg + CIDX'(1);
                end
            end
            S_GENE_B:
            begin
                gene_a_reg <= cur_rdata_reg;
            end
            S_GENE_C:
            begin
                gene_b_reg    <= cur_rdata_reg;
                cut_reg       <= '0;
                mut_phase_reg <= 1'b0;
            end
            S_DRAW:
            begin
                draw_reg <= lfsr_next;
            end
            S_MUL:
            begin
                prod_reg <= 64'(draw_reg) * 64'(grb_pkg::RECIP);
            end
            S_CMP:
            begin
                if (!mut_phase_reg)
                begin
                    if (draw_mod <= xo_thr_reg)
                    begin
                        cut_reg <= cut_reg + CUTW'(1);
                    end
                end
                else
                begin
                    if (draw_mod > mu_thr_reg)
                    begin
                        child_reg[bit_reg] <= ~child_reg[bit_reg];
                    end
                    bit_reg <= bit_reg + BITW'(1);
                end
            end
            S_CHILD:
            begin
                child_reg     <= (gene_a_reg & ~low_mask) | (gene_b_reg & low_mask);
                mut_phase_reg <= 1'b1;
                bit_reg       <= '0;
            end
            S_WRITE:
            begin
                res_chrom_reg <= child_reg;
                res_pa_reg    <= pa_ext[grb_pkg::PAR_W-1:0];
                res_pb_reg    <= pb_ext[grb_pkg::PAR_W-1:0];
                res_cut_reg   <= cut_reg;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_chrom_reg  <= grb_pkg::WORD_W'(res_chrom_reg);
            out_pa_reg     <= res_pa_reg;
            out_pb_reg     <= res_pb_reg;
            out_cut_reg    <= grb_pkg::CUT_W'(res_cut_reg);
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid          = out_vld_reg;
    assign rsp.chromosome_out = out_chrom_reg;
    assign rsp.parent_first   = out_pa_reg;
    assign rsp.parent_second  = out_pb_reg;
    assign rsp.cut_point      = out_cut_reg;
    assign rsp.status         = out_status_reg;

    // A response with an error status carries no chromosome and no cut point.
    a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != grb_pkg::ST_OK) |->
        (rsp.chromosome_out == '0 && rsp.cut_point == '0))
        else $error("error response carries payload");

    // The random source must never fall into the all-zero lockup word.
    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("LFSR reached zero");

    // The remainder unit only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV_WAIT)
        else $error("remainder finished outside its wait state");

    // The request side is closed for the whole commit sweep.
    a_sweep_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |=> !req.ready || $past(sweep_idx_reg) == LAST_IDX)
        else $error("request accepted during sweep");

endmodule
